// ===== sv/utf8sd_pkg.sv =====
`timescale 1ns / 1ps

package utf8sd_pkg;

    // Configuration register indexes
    localparam logic CFG_MAX_CODE_POINT    = 1'b0;
    localparam logic CFG_REPLACEMENT_VALUE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [31:0] MAX_CODE_POINT_RESET    = 32'h7FFF_FFFF;
    localparam logic [31:0] REPLACEMENT_VALUE_RESET = 32'h0000_FFFD;

    // Byte range limits
    localparam logic [7:0] CONT_MIN       = 8'h80;
    localparam logic [7:0] CONT_MAX       = 8'hBF;
    localparam logic [7:0] LEAD_MIN_LEGAL = 8'hC2;
    localparam logic [7:0] LEAD_MAX_LEGAL = 8'hF4;
    localparam logic [7:0] LEAD_E0        = 8'hE0;
    localparam logic [7:0] LEAD_F0        = 8'hF0;
    localparam logic [7:0] LEAD_F4        = 8'hF4;
    localparam logic [7:0] E0_SECOND_MIN  = 8'hA0;
    localparam logic [7:0] F0_SECOND_MIN  = 8'h90;
    localparam logic [7:0] F4_SECOND_MAX  = 8'h8F;

    // Longest sequence still covered by the legality rules (trailing bytes)
    localparam logic [2:0] MAX_LEGAL_EXTRA = 3'd3;

    // Input transfer
    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_string;
    } in_t;

    // Output transfer
    typedef struct packed {
        logic [31:0] code_point;
        logic        sequence_legal;
        logic        string_legal;
        logic        truncated;
        logic        last;
    } out_t;

    // Decoded sequence handed from the decode stage to the finish stage
    typedef struct packed {
        logic [31:0] acc;
        logic [2:0]  extra;
        logic        seq_ok;
        logic        str_ok;
        logic        truncated;
        logic        last;
    } mid_t;

    // Number of trailing bytes implied by a lead byte
    function automatic logic [2:0] extra_for_lead(input logic [7:0] b);
        logic [2:0] e;
        if (b < 8'hC0)
            e = 3'd0;
        else if (b < 8'hE0)
            e = 3'd1;
        else if (b < 8'hF0)
            e = 3'd2;
        else if (b < 8'hF8)
            e = 3'd3;
        else if (b < 8'hFC)
            e = 3'd4;
        else
            e = 3'd5;
        return e;
    endfunction

    // Offset removed from the accumulator per trailing-byte count
    function automatic logic [31:0] offset_by_extra(input logic [2:0] extra);
        logic [31:0] o;
        case (extra)
            3'd1:    o = 32'h0000_3080;
            3'd2:    o = 32'h000E_2080;
            3'd3:    o = 32'h03C8_2080;
            3'd4:    o = 32'hFA08_2080;
            3'd5:    o = 32'h8208_2080;
            default: o = 32'h0000_0000;
        endcase
        return o;
    endfunction

endpackage

// ===== sv/utf8sd_decode.sv =====
`timescale 1ns / 1ps

module utf8sd_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  utf8sd_pkg::in_t   in_data,
    output logic              mid_valid,
    input  logic              mid_stall,
    output utf8sd_pkg::mid_t  mid_data
);
    import utf8sd_pkg::*;

    // Sequence state
    logic [7:0]  lead_reg, lead_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  len_reg, len_next;
    logic        seq_ok_reg, seq_ok_next;
    logic        str_ok_reg, str_ok_next;

    // Stage output register
    logic        mid_valid_reg, mid_valid_next;
    mid_t        mid_reg, mid_next;

    logic        accept;
    logic        produce;
    logic [7:0]  b;
    logic [2:0]  ext;
    logic [31:0] acc_upd;
    logic [2:0]  rem_upd;
    logic [2:0]  len_upd;
    logic        ok_upd;
    logic        second;
    logic        str_upd;

    assign in_stall = mid_valid_reg && mid_stall;
    assign accept   = in_valid && !in_stall;
    assign b        = in_data.byte_value;
    assign ext      = extra_for_lead(b);
    assign second   = (rem_reg == (len_reg - 3'd1));

    // Fold one byte into the open sequence, or open a new one
    always_comb
    begin
        if (rem_reg == 3'd0)
        begin
            acc_upd = {24'd0, b};
            len_upd = ext + 3'd1;
            rem_upd = ext;
            ok_upd  = !(ext > MAX_LEGAL_EXTRA)
                      && !((b >= CONT_MIN) && (b < LEAD_MIN_LEGAL))
                      && !(b > LEAD_MAX_LEGAL);
        end
        else
        begin
            acc_upd = {acc_reg[25:0], 6'd0} + {24'd0, b};
            len_upd = len_reg;
            rem_upd = rem_reg - 3'd1;
            ok_upd  = seq_ok_reg && !(b > CONT_MAX);
            if (second)
            begin
                if (lead_reg == LEAD_E0)
                    ok_upd = ok_upd && !(b < E0_SECOND_MIN);
                else if (lead_reg == LEAD_F0)
                    ok_upd = ok_upd && !(b < F0_SECOND_MIN);
                else if (lead_reg == LEAD_F4)
                    ok_upd = ok_upd && !(b > F4_SECOND_MAX);
                else
                    ok_upd = ok_upd && !(b < CONT_MIN);
            end
            else
                ok_upd = ok_upd && !(b < CONT_MIN);
        end
    end

    assign str_upd = str_ok_reg && ok_upd;

    // Next state and stage register
    always_comb
    begin
        lead_next      = lead_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        seq_ok_next    = seq_ok_reg;
        str_ok_next    = str_ok_reg;
        produce        = 1'b0;
        mid_next       = mid_reg;

        if (accept)
        begin
            if (rem_upd != 3'd0)
            begin
                if (in_data.end_of_string)
                begin
                    // string cut off inside a sequence
                    produce            = 1'b1;
                    mid_next.acc       = 32'd0;
                    mid_next.extra     = 3'd0;
                    mid_next.seq_ok    = 1'b0;
                    mid_next.str_ok    = 1'b0;
                    mid_next.truncated = 1'b1;
                    mid_next.last      = 1'b1;
                    lead_next          = 8'd0;
                    acc_next           = 32'd0;
                    rem_next           = 3'd0;
                    len_next           = 3'd0;
                    seq_ok_next        = 1'b1;
                    str_ok_next        = 1'b1;
                end
                else
                begin
                    lead_next   = (rem_reg == 3'd0) ? b : lead_reg;
                    acc_next    = acc_upd;
                    rem_next    = rem_upd;
                    len_next    = len_upd;
                    seq_ok_next = ok_upd;
                end
            end
            else
            begin
                // sequence complete
                produce            = 1'b1;
                mid_next.acc       = acc_upd;
                mid_next.extra     = len_upd - 3'd1;
                mid_next.seq_ok    = ok_upd;
                mid_next.str_ok    = str_upd;
                mid_next.truncated = 1'b0;
                mid_next.last      = in_data.end_of_string;
                lead_next          = 8'd0;
                acc_next           = 32'd0;
                rem_next           = 3'd0;
                len_next           = 3'd0;
                seq_ok_next        = 1'b1;
                str_ok_next        = in_data.end_of_string ? 1'b1 : str_upd;
            end
        end

        if (accept)
            mid_valid_next = produce;
        else if (!mid_stall)
            mid_valid_next = 1'b0;
        else
            mid_valid_next = mid_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg      <= 8'd0;
            acc_reg       <= 32'd0;
            rem_reg       <= 3'd0;
            len_reg       <= 3'd0;
            seq_ok_reg    <= 1'b1;
            str_ok_reg    <= 1'b1;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            lead_reg      <= lead_next;
            acc_reg       <= acc_next;
            rem_reg       <= rem_next;
            len_reg       <= len_next;
            seq_ok_reg    <= seq_ok_next;
            str_ok_reg    <= str_ok_next;
            mid_valid_reg <= mid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
    end

    assign mid_valid = mid_valid_reg;
    assign mid_data  = mid_reg;

endmodule

// ===== sv/utf8sd_finish.sv =====
`timescale 1ns / 1ps

module utf8sd_finish (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              mid_valid,
    output logic              mid_stall,
    input  utf8sd_pkg::mid_t  mid_data,
    output logic              out_valid,
    input  logic              out_stall,
    output utf8sd_pkg::out_t  out_data
);
    import utf8sd_pkg::*;

    logic [31:0] max_cp_reg;
    logic [31:0] repl_reg;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg, out_next;
    logic        load;
    logic [31:0] value;

    assign mid_stall = out_valid_reg && out_stall;
    assign load      = mid_valid && !mid_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cp_reg <= MAX_CODE_POINT_RESET;
            repl_reg   <= REPLACEMENT_VALUE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_CODE_POINT:    max_cp_reg <= cfg_data;
                CFG_REPLACEMENT_VALUE: repl_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Remove length offset, replace values above the maximum, zero a truncated result
    always_comb
    begin
        value = mid_data.acc - offset_by_extra(mid_data.extra);
        if (value > max_cp_reg)
            value = repl_reg;
        if (mid_data.truncated)
            value = 32'd0;

        out_next                = out_reg;
        if (load)
        begin
            out_next.code_point     = value;
            out_next.sequence_legal = mid_data.seq_ok;
            out_next.string_legal   = mid_data.str_ok;
            out_next.truncated      = mid_data.truncated;
            out_next.last           = mid_data.last;
        end

        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/utf8_stream_decode_validate_top.sv =====
`timescale 1ns / 1ps
// UTF-8 stream decoder and validator, one byte per transfer.
// Throughput: one byte per cycle while in_stall is low; a result leaves on the byte that
// closes a sequence. The closing byte passes the decode register, then the output
// register with offset and replacement; a stall at either stage holds it.
// Reset (rst_n, async low): no open sequence, string flag set, max 0x7FFFFFFF,
// replacement 0xFFFD, both stages empty.

module utf8_stream_decode_validate_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  utf8sd_pkg::in_t   in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output utf8sd_pkg::out_t  out_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data
);
    import utf8sd_pkg::*;

    logic mid_valid;
    logic mid_stall;
    mid_t mid_data;

    // Byte decode and sequence state
    utf8sd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .mid_valid (mid_valid),
        .mid_stall (mid_stall),
        .mid_data  (mid_data)
    );

    // Offset, replacement above the maximum and output register
    utf8sd_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mid_valid (mid_valid),
        .mid_stall (mid_stall),
        .mid_data  (mid_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== sv/utf8sd_checker.sv =====
`timescale 1ns / 1ps

module utf8sd_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_stall,
    input  utf8sd_pkg::out_t  out_data
);
    import utf8sd_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // Truncated result closes the string with no value
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.truncated |-> out_data.last && out_data.code_point == 32'd0)
        else $error("truncated result not last or nonzero");

    a_trunc_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.truncated
            |-> !out_data.sequence_legal && !out_data.string_legal)
        else $error("truncated result flagged legal");

    // Illegal sequence poisons the string flag
    a_str_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.sequence_legal |-> !out_data.string_legal)
        else $error("string legal after illegal sequence");

endmodule

bind utf8_stream_decode_validate_top utf8sd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
